[design/ptsb_pkg.sv]
// Shared types and codes for the periodic timer slot bank.
package ptsb_pkg;

    localparam logic [2:0] CMD_RESERVE = 3'd0;
    localparam logic [2:0] CMD_UPDATE  = 3'd1;
    localparam logic [2:0] CMD_START   = 3'd2;
    localparam logic [2:0] CMD_STOP    = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;
    localparam logic [2:0] CMD_READ    = 3'd5;
    localparam logic [2:0] CMD_TICK    = 3'd6;
    localparam logic [2:0] CMD_UNDEF   = 3'd7;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_FIRE  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_RESERVE,
        OP_UPDATE,
        OP_START,
        OP_STOP,
        OP_CLEAR,
        OP_READ,
        OP_TICK,
        OP_BAD
    } op_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  slot_id;
        logic [15:0] interval;
        logic [15:0] exec_limit;
        logic        has_handler;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        status;
        logic [7:0]  result_slot;
        logic        prev_running;
        logic [15:0] exec_count;
        logic [15:0] limit_out;
        logic        last;
    } evt_item_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  slot_id;
        logic [15:0] interval;
        logic [15:0] exec_limit;
        logic        has_handler;
    } entry_t;

endpackage

[design/ptsb_front.sv]
// Command decoder: accepts commands and classifies them into queue entries.
module ptsb_front (
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  ptsb_pkg::cmd_item_t cmd_data,
    output logic               push,
    output ptsb_pkg::entry_t   push_data,
    input  logic               full
);
    import ptsb_pkg::*;

    op_t op;

    always_comb
    begin
        case (cmd_data.command)
            CMD_RESERVE: op = OP_RESERVE;
            CMD_UPDATE:  op = OP_UPDATE;
            CMD_START:   op = OP_START;
            CMD_STOP:    op = OP_STOP;
            CMD_CLEAR:   op = OP_CLEAR;
            CMD_READ:    op = OP_READ;
            CMD_TICK:    op = OP_TICK;
            default:     op = OP_BAD;
        endcase
    end

    assign cmd_stall             = full;
    assign push                  = cmd_valid && !full;
    assign push_data.op          = op;
    assign push_data.slot_id     = cmd_data.slot_id;
    assign push_data.interval    = cmd_data.interval;
    assign push_data.exec_limit  = cmd_data.exec_limit;
    assign push_data.has_handler = cmd_data.has_handler;
endmodule

[design/ptsb_queue.sv]
// Two-entry queue between the decoder and the slot engine.
module ptsb_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ptsb_pkg::entry_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output ptsb_pkg::entry_t head
);
    import ptsb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    entry_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   fill_reg;

    assign full       = fill_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign head_valid = fill_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end
endmodule

[design/ptsb_back.sv]
// Slot engine: holds the slot table, executes commands and walks slots on a tick.
module ptsb_back #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  ptsb_pkg::entry_t    head,
    output logic                pop,
    output logic                evt_valid,
    input  logic                evt_stall,
    output ptsb_pkg::evt_item_t evt_data
);
    import ptsb_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] res_reg, res_next;
    logic [15:0]      iv_reg [SLOT_COUNT];
    logic [15:0]      tc_reg [SLOT_COUNT];
    logic [15:0]      lim_reg [SLOT_COUNT];
    logic [15:0]      ec_reg [SLOT_COUNT];
    logic             run_reg [SLOT_COUNT];
    logic             hnd_reg [SLOT_COUNT];
    logic [15:0]      iv_next [SLOT_COUNT];
    logic [15:0]      tc_next [SLOT_COUNT];
    logic [15:0]      lim_next [SLOT_COUNT];
    logic [15:0]      ec_next [SLOT_COUNT];
    logic             run_next [SLOT_COUNT];
    logic             hnd_next [SLOT_COUNT];
    logic             out_valid_reg, out_valid_next;
    evt_item_t        out_reg, out_next;

    logic             free;
    logic             id_ok;
    logic [IDX_W-1:0] id_idx;
    logic [IDX_W-1:0] res_idx;
    logic [15:0]      ec_inc;
    evt_item_t        reply;

    assign free    = !out_valid_reg || !evt_stall;
    assign id_ok   = head.slot_id < {{(8-CNT_W){1'b0}}, res_reg};
    assign id_idx  = head.slot_id[IDX_W-1:0];
    assign res_idx = res_reg[IDX_W-1:0];
    assign ec_inc  = ec_reg[idx_reg] + 16'd1;

    assign evt_valid = out_valid_reg;
    assign evt_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        iv_next        = iv_reg;
        tc_next        = tc_reg;
        lim_next       = lim_reg;
        ec_next        = ec_reg;
        run_next       = run_reg;
        hnd_next       = hnd_reg;
        out_valid_next = out_valid_reg && evt_stall;
        out_next       = out_reg;
        pop            = 1'b0;

        reply             = '0;
        reply.kind        = KIND_REPLY;
        reply.status      = STATUS_ERR;
        reply.last        = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid && free)
                begin
                    case (head.op)
                        OP_RESERVE:
                        begin
                            if (res_reg != CNT_W'(SLOT_COUNT))
                            begin
                                iv_next[res_idx]  = head.interval;
                                tc_next[res_idx]  = '0;
                                lim_next[res_idx] = head.exec_limit;
                                ec_next[res_idx]  = '0;
                                hnd_next[res_idx] = head.has_handler;
                                res_next          = res_reg + 1'b1;
                                reply.status      = STATUS_OK;
                                reply.result_slot = 8'(res_reg);
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (id_ok)
                            begin
                                iv_next[id_idx]   = head.interval;
                                tc_next[id_idx]   = '0;
                                lim_next[id_idx]  = head.exec_limit;
                                ec_next[id_idx]   = '0;
                                hnd_next[id_idx]  = head.has_handler;
                                reply.status      = STATUS_OK;
                                reply.result_slot = head.slot_id;
                            end
                        end
                        OP_START, OP_STOP:
                        begin
                            if (id_ok)
                            begin
                                run_next[id_idx]   = head.op == OP_START;
                                reply.status       = STATUS_OK;
                                reply.prev_running = run_reg[id_idx];
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (id_ok)
                            begin
                                ec_next[id_idx] = '0;
                                reply.status    = STATUS_OK;
                            end
                        end
                        OP_READ:
                        begin
                            if (id_ok)
                            begin
                                reply.status     = STATUS_OK;
                                reply.exec_count = ec_reg[id_idx];
                            end
                        end
                        OP_TICK:
                        begin
                            state_next = ST_WALK;
                            idx_next   = '0;
                        end
                        default:
                        begin
                            reply.status = STATUS_ERR;
                        end
                    endcase
                    if (head.op != OP_TICK)
                    begin
                        pop            = 1'b1;
                        out_valid_next = 1'b1;
                        out_next       = reply;
                    end
                end
            end
            ST_WALK:
            begin
                if (free)
                begin
                    if (run_reg[idx_reg])
                    begin
                        if (tc_reg[idx_reg] < iv_reg[idx_reg])
                        begin
                            tc_next[idx_reg] = tc_reg[idx_reg] + 16'd1;
                        end
                        else
                        begin
                            tc_next[idx_reg] = '0;
                            if (lim_reg[idx_reg] == '0 || ec_reg[idx_reg] < lim_reg[idx_reg])
                            begin
                                // wrap on reaching a nonzero limit
                                if (lim_reg[idx_reg] != '0 && ec_inc == lim_reg[idx_reg])
                                    ec_next[idx_reg] = '0;
                                else
                                    ec_next[idx_reg] = ec_inc;
                                if (hnd_reg[idx_reg])
                                begin
                                    out_valid_next       = 1'b1;
                                    out_next             = '0;
                                    out_next.kind        = KIND_FIRE;
                                    out_next.status      = STATUS_OK;
                                    out_next.result_slot = 8'(idx_reg);
                                    out_next.exec_count  = ec_reg[idx_reg];
                                    out_next.limit_out   = lim_reg[idx_reg];
                                    out_next.last        = 1'b0;
                                end
                            end
                        end
                    end
                    if (idx_reg == IDX_W'(SLOT_COUNT - 1))
                        state_next = ST_DONE;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.kind  = KIND_DONE;
                    out_next.last  = 1'b1;
                    pop            = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                iv_reg[i]  <= '0;
                tc_reg[i]  <= '0;
                lim_reg[i] <= '0;
                ec_reg[i]  <= '0;
                run_reg[i] <= 1'b0;
                hnd_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            iv_reg        <= iv_next;
            tc_reg        <= tc_next;
            lim_reg       <= lim_next;
            ec_reg        <= ec_next;
            run_reg       <= run_next;
            hnd_reg       <= hnd_next;
        end
    end
endmodule

[design/periodic_timer_slot_bank_unit.sv]
// Periodic timer slot bank: top level.
// Commands come in on the cmd channel (cmd_valid, cmd_stall, cmd_data) and
// results leave on the evt channel (evt_valid, evt_stall, evt_data).
// A transfer happens on a rising edge with valid high and stall low.
// The decoder pushes each command into a two-entry queue; the slot engine
// pops it and runs it while the decoder keeps taking commands until the
// queue is full.
// Non-tick commands give one reply: the slot engine takes the command from
// the queue head and loads the reply into the output register; it can leave
// at the following edge.
// A tick walks the slot table one slot per cycle while the evt channel is
// not stalled: the idle state starts the walk, the walk state visits every
// slot and issues any fire events on the way, then the done state gives the
// tick-finished result (last set).
// A stalled evt channel holds the output register and freezes the slot
// engine; the queue then fills and cmd_stall rises.
// Reset clears all slots, the reserved count, the queue and the output.
module periodic_timer_slot_bank_unit #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  ptsb_pkg::cmd_item_t cmd_data,
    output logic                evt_valid,
    input  logic                evt_stall,
    output ptsb_pkg::evt_item_t evt_data
);
    import ptsb_pkg::*;

    logic   push;
    entry_t push_data;
    logic   full;
    logic   pop;
    logic   head_valid;
    entry_t head;

    ptsb_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    ptsb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    ptsb_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt_data   (evt_data)
    );
endmodule

[tb/sv/tb.sv]
// Testbench for the periodic timer slot bank: random and directed commands, scoreboard check.
`timescale 1ns / 1ps

module tb;
    import ptsb_pkg::*;

    localparam int SLOTS = 16;

    class timer_scoreboard;
        int unsigned reserved;
        logic [15:0] ivl [SLOTS];
        logic [15:0] tcnt [SLOTS];
        logic [15:0] lim [SLOTS];
        logic [15:0] ecnt [SLOTS];
        logic        run [SLOTS];
        logic        hnd [SLOTS];
        evt_item_t   pending_events [$];
        int          errors;

        function new();
            reserved = 0;
            errors = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                ivl[i] = '0; tcnt[i] = '0; lim[i] = '0; ecnt[i] = '0;
                run[i] = 1'b0; hnd[i] = 1'b0;
            end
        endfunction

        function evt_item_t reply(logic st);
            evt_item_t e;
            e = '0;
            e.kind = KIND_REPLY;
            e.status = st;
            e.last = 1'b1;
            return e;
        endfunction

        function void fill(int id, cmd_item_t c);
            hnd[id] = c.has_handler;
            lim[id] = c.exec_limit;
            ecnt[id] = '0;
            ivl[id] = c.interval;
            tcnt[id] = '0;
        endfunction

        // Work out the results of one accepted command.
        function void note_command(cmd_item_t c);
            evt_item_t e;
            logic ok;
            ok = (c.slot_id < reserved) && (c.slot_id < SLOTS);
            e = reply(ok ? STATUS_OK : STATUS_ERR);
            case (c.command)
                CMD_RESERVE:
                begin
                    if (reserved < SLOTS)
                    begin
                        fill(reserved, c);
                        e = reply(STATUS_OK);
                        e.result_slot = reserved[7:0];
                        reserved++;
                    end
                    else
                        e = reply(STATUS_ERR);
                    pending_events.push_back(e);
                end
                CMD_UPDATE:
                begin
                    if (ok)
                    begin
                        fill(c.slot_id, c);
                        e.result_slot = c.slot_id;
                    end
                    pending_events.push_back(e);
                end
                CMD_START, CMD_STOP:
                begin
                    if (ok)
                    begin
                        e.prev_running = run[c.slot_id];
                        run[c.slot_id] = (c.command == CMD_START);
                    end
                    pending_events.push_back(e);
                end
                CMD_CLEAR:
                begin
                    if (ok)
                        ecnt[c.slot_id] = '0;
                    pending_events.push_back(e);
                end
                CMD_READ:
                begin
                    if (ok)
                        e.exec_count = ecnt[c.slot_id];
                    pending_events.push_back(e);
                end
                CMD_TICK:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!run[i])
                            continue;
                        if (tcnt[i] < ivl[i])
                        begin
                            tcnt[i]++;
                            continue;
                        end
                        tcnt[i] = '0;
                        if (lim[i] == 0 || ecnt[i] < lim[i])
                        begin
                            if (hnd[i])
                            begin
                                e = '0;
                                e.kind = KIND_FIRE;
                                e.result_slot = i[7:0];
                                e.exec_count = ecnt[i];
                                e.limit_out = lim[i];
                                pending_events.push_back(e);
                            end
                            ecnt[i]++;
                        end
                        if (lim[i] != 0)
                            ecnt[i] = ecnt[i] % lim[i];
                    end
                    e = '0;
                    e.kind = KIND_DONE;
                    e.last = 1'b1;
                    pending_events.push_back(e);
                end
                default:
                    pending_events.push_back(reply(STATUS_ERR));
            endcase
        endfunction

        function void check_event(evt_item_t got);
            evt_item_t exp;
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected event, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            exp = pending_events.pop_front();
            if (got.kind != exp.kind || got.status != exp.status
                || got.result_slot != exp.result_slot
                || got.prev_running != exp.prev_running
                || got.exec_count != exp.exec_count || got.limit_out != exp.limit_out
                || got.last != exp.last)
            begin
                $display("%0t: mismatch, expected %h, actual %h", $time, exp, got);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_item_t cmd_data;
    logic      evt_valid;
    logic      evt_stall;
    evt_item_t evt_data;

    timer_scoreboard board;
    bit        quiet;        // no idling in the final part
    bit        hold_evt;     // long receiver hold-off request
    int        hold_cycles;

    periodic_timer_slot_bank_unit #(.SLOT_COUNT(SLOTS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_data(cmd_data),
        .evt_valid(evt_valid), .evt_stall(evt_stall), .evt_data(evt_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // Check each accepted result.
    always @(posedge clk)
        if (rst_n && evt_valid && !evt_stall)
            board.check_event(evt_data);

    // Receiver stall: random bursts, plus one long hold-off on request.
    initial
    begin
        int n;
        evt_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_evt)
            begin
                evt_stall <= 1'b1;
                for (int i = 0; i < hold_cycles; i++)
                    @(posedge clk);
                evt_stall <= 1'b0;
                hold_evt = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 15);
                evt_stall <= 1'b1;
                for (int i = 1; i < n; i++)
                    @(posedge clk);
                @(posedge clk);
                evt_stall <= 1'b0;
            end
            else
                evt_stall <= 1'b0;
        end
    end

    task automatic send(cmd_item_t c);
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        board.note_command(c);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic send_op(logic [2:0] op, logic [7:0] id, logic [15:0] iv,
                           logic [15:0] lm, logic h);
        cmd_item_t c;
        c.command = op;
        c.slot_id = id;
        c.interval = iv;
        c.exec_limit = lm;
        c.has_handler = h;
        send(c);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        while (board.pending_events.size() != 0)
            @(posedge clk);
    endtask

    function automatic cmd_item_t random_item(bit wellformed);
        cmd_item_t c;
        c = '0;
        c.command = wellformed ? (($urandom_range(0, 2) == 0) ? CMD_TICK
                                 : 3'($urandom_range(0, 5)))
                               : 3'($urandom_range(0, 7));
        c.slot_id = wellformed ? 8'($urandom_range(0, SLOTS - 1)) : 8'($urandom);
        // mostly short intervals and small limits so slots fire often
        c.interval = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 3));
        c.exec_limit = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 4));
        c.has_handler = ($urandom_range(0, 3) != 0);
        return c;
    endfunction

    initial
    begin
        board = new();
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd_data = '0;
        quiet = 1'b0;
        hold_evt = 1'b0;
        hold_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: commands on unreserved slots, bad command, then fills.
        send_op(CMD_READ, 8'd0, 16'd0, 16'd0, 1'b0);
        send_op(CMD_START, 8'd255, 16'hFFFF, 16'hFFFF, 1'b1);
        send_op(CMD_UNDEF, 8'd0, 16'd0, 16'd0, 1'b0);
        send_op(CMD_TICK, 8'd0, 16'd0, 16'd0, 1'b0);
        send_op(CMD_RESERVE, 8'd0, 16'd0, 16'd0, 1'b1);        // free counting
        send_op(CMD_RESERVE, 8'd0, 16'd1, 16'd2, 1'b1);        // wraps at 2
        send_op(CMD_RESERVE, 8'd0, 16'd0, 16'd3, 1'b0);        // no handler
        send_op(CMD_RESERVE, 8'd0, 16'hFFFF, 16'hFFFF, 1'b1);
        send_op(CMD_START, 8'd0, 16'd0, 16'd0, 1'b0);
        send_op(CMD_START, 8'd0, 16'd0, 16'd0, 1'b0);
        send_op(CMD_START, 8'd1, 16'd0, 16'd0, 1'b0);
        send_op(CMD_START, 8'd2, 16'd0, 16'd0, 1'b0);
        send_op(CMD_START, 8'd3, 16'd0, 16'd0, 1'b0);
        for (int i = 0; i < 4; i++)
            send_op(CMD_TICK, 8'd0, 16'd0, 16'd0, 1'b0);
        send_op(CMD_READ, 8'd2, 16'd0, 16'd0, 1'b0);
        send_op(CMD_CLEAR, 8'd2, 16'd0, 16'd0, 1'b0);
        send_op(CMD_UPDATE, 8'd1, 16'd0, 16'd1, 1'b1);
        send_op(CMD_STOP, 8'd3, 16'd0, 16'd0, 1'b0);
        send_op(CMD_STOP, 8'd200, 16'd0, 16'd0, 1'b0);

        // Sender pause until everything is back.
        drain();

        // Receiver long hold-off while commands keep coming.
        hold_cycles = 300;
        hold_evt = 1'b1;
        for (int i = 0; i < 12; i++)
            send(random_item(1'b1));

        // Random part; fill the bank with a burst of reserves first.
        for (int i = 0; i < 14; i++)
            send_op(CMD_RESERVE, 8'($urandom), 16'($urandom_range(0, 3)),
                    16'($urandom_range(0, 4)), 1'($urandom));
        send_op(CMD_RESERVE, 8'd0, 16'd0, 16'd0, 1'b0);        // bank full
        for (int i = 0; i < SLOTS; i++)
            send_op(CMD_START, 8'(i), 16'd0, 16'd0, 1'b0);
        for (int i = 0; i < 55; i++)
        begin
            if (i == 40)
                quiet = 1'b1;
            send(random_item($urandom_range(0, 7) != 0));
        end

        drain();
        repeat (50) @(posedge clk);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
